// File: design/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the console checker.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// File: design/txcon_pkg.sv
// -----------------------------------------------------------------------------
// Text console package
// Request codes, controller states and cell constants of the text console.
// -----------------------------------------------------------------------------
package txcon_pkg;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    ST_SWEEP = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  localparam logic [7:0] BlankChar   = 8'h20;
  localparam logic [7:0] NewlineChar = 8'h0A;
  localparam logic [7:0] ColorReset  = 8'h07;

endpackage

// File: design/text_console_writer_core.sv
// -----------------------------------------------------------------------------
// Text console writer core
// Character-cell console held in one cell memory, addressed through a
// rotating top-row offset so that a scroll only blanks one row.
// -----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tuser: req_type; tdata: ch, cell_index
// m_axis    out        tuser: scrolled; tdata: cursor_pos, cell_char, cell_color
// cfg       in         text_color, one write per cycle
//
// A put, newline or read transaction passes from IDLE through EXEC to DONE, where its
// result is registered onto m_axis; a read uses the registered read of the cell memory.
// A scroll blanks COLUMNS cells and a clear blanks ROWS*COLUMNS cells in the SWEEP state.
// After reset all ROWS*COLUMNS cells of the memory are blanked before s_axis_tready.
// One transaction is in work at a time; a result waiting on m_axis_tready holds
// the following transaction in its last cycle.
// -----------------------------------------------------------------------------
module text_console_writer_core
  import txcon_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // ch [7:0], cell_index [18:8], zero [23:19]
  input  logic [1:0]  s_axis_tuser,  // req_type [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // cursor_pos [10:0], cell_char [18:11],
                                     // cell_color [26:19], zero [31:27]
  output logic [0:0]  m_axis_tuser,  // scrolled [0]
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam int CellCount = ROWS * COLUMNS;
  localparam int AW        = $clog2(CellCount);
  localparam int PW        = AW + 1;
  localparam int SW        = ((AW > 11) ? AW : 11) + 1;
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);

  localparam logic [PW-1:0] CellCountP = PW'(CellCount);
  localparam logic [PW-1:0] ColumnsP   = PW'(COLUMNS);
  localparam logic [AW-1:0] LastAddr   = AW'(CellCount - 1);
  localparam logic [AW-1:0] LastRowBase = AW'((ROWS - 1) * COLUMNS);
  localparam logic [CW-1:0] LastCol    = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LastRow    = RW'(ROWS - 1);

  logic [15:0] mem [CellCount];
  logic [15:0] rdata_q;

  state_e      state_q, state_d;
  req_e        req_q;
  logic [7:0]  ch_q;
  logic [10:0] idx_q;
  logic [7:0]  color_q;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] row_base_q, row_base_d;
  logic [AW-1:0] top_base_q, top_base_d;
  logic [AW-1:0] sweep_addr_q, sweep_addr_d;
  logic [AW-1:0] sweep_end_q, sweep_end_d;
  logic [7:0]    sweep_color_q, sweep_color_d;
  logic          scrolled_q, scrolled_d;
  logic          rd_ok_q, rd_ok_d;
  logic          m_valid_q, m_valid_d;
  logic [31:0]   m_data_q, m_data_d;
  logic          m_user_q, m_user_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;

  logic [PW-1:0] cur_sum, rd_sum, tb_sum, pos_sum;
  logic [AW-1:0] cur_phys, rd_phys, tb_next;
  logic [SW-1:0] idx_ext;
  logic          rd_in_range, s_accept, out_free, next_row;
  logic [7:0]    out_char, out_color;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  assign cur_sum  = PW'(top_base_q) + PW'(row_base_q) + PW'(col_q);
  assign cur_phys = (cur_sum >= CellCountP) ? AW'(cur_sum - CellCountP) : AW'(cur_sum);

  assign idx_ext     = SW'(idx_q);
  assign rd_in_range = idx_ext < SW'(CellCount);
  assign rd_sum      = PW'(idx_ext[AW-1:0]) + PW'(top_base_q);
  assign rd_phys     = (rd_sum >= CellCountP) ? AW'(rd_sum - CellCountP) : AW'(rd_sum);

  assign tb_sum  = PW'(top_base_q) + ColumnsP;
  assign tb_next = (tb_sum >= CellCountP) ? AW'(tb_sum - CellCountP) : AW'(tb_sum);

  assign pos_sum   = PW'(row_base_q) + PW'(col_q);
  assign out_char  = (req_q == REQ_READ && rd_ok_q) ? rdata_q[7:0] : 8'h00;
  assign out_color = (req_q == REQ_READ && rd_ok_q) ? rdata_q[15:8] : 8'h00;

  always_comb begin
    state_d       = state_q;
    col_d         = col_q;
    row_d         = row_q;
    row_base_d    = row_base_q;
    top_base_d    = top_base_q;
    sweep_addr_d  = sweep_addr_q;
    sweep_end_d   = sweep_end_q;
    sweep_color_d = sweep_color_q;
    scrolled_d    = scrolled_q;
    rd_ok_d       = rd_ok_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_data_d      = m_data_q;
    m_user_d      = m_user_q;
    mem_we        = 1'b0;
    mem_waddr     = cur_phys;
    mem_wdata     = {color_q, ch_q};
    mem_re        = 1'b0;
    mem_raddr     = rd_phys;
    next_row      = 1'b0;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_SWEEP: begin
        mem_we       = 1'b1;
        mem_waddr    = sweep_addr_q;
        mem_wdata    = {sweep_color_q, BlankChar};
        sweep_addr_d = sweep_addr_q + AW'(1);
        if (sweep_addr_q == sweep_end_q) begin
          state_d = scrolled_q || (req_q == REQ_CLEAR) ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d    = ST_EXEC;
          scrolled_d = 1'b0;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (req_q)
          REQ_PUT: begin
            if (ch_q == NewlineChar) begin
              next_row = 1'b1;
            end else begin
              mem_we = 1'b1;
              if (col_q == LastCol) begin
                next_row = 1'b1;
              end else begin
                col_d = col_q + CW'(1);
              end
            end
            if (next_row) begin
              col_d = '0;
              if (row_q == LastRow) begin
                scrolled_d    = 1'b1;
                top_base_d    = tb_next;
                sweep_addr_d  = top_base_q;
                sweep_end_d   = AW'(tb_sum - PW'(1));
                sweep_color_d = color_q;
                row_base_d    = LastRowBase;
                state_d       = ST_SWEEP;
              end else begin
                row_d      = row_q + RW'(1);
                row_base_d = AW'(PW'(row_base_q) + ColumnsP);
              end
            end
          end
          REQ_CLEAR: begin
            col_d         = '0;
            row_d         = '0;
            row_base_d    = '0;
            top_base_d    = '0;
            sweep_addr_d  = '0;
            sweep_end_d   = LastAddr;
            sweep_color_d = color_q;
            state_d       = ST_SWEEP;
          end
          REQ_READ: begin
            mem_re  = rd_in_range;
            rd_ok_d = rd_in_range;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'd0, out_color, out_char, 11'(pos_sum)};
          m_user_d  = scrolled_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      color_q       <= ColorReset;
      col_q         <= '0;
      row_q         <= '0;
      row_base_q    <= '0;
      top_base_q    <= '0;
      sweep_addr_q  <= '0;
      sweep_end_q   <= LastAddr;
      sweep_color_q <= ColorReset;
      scrolled_q    <= 1'b0;
      rd_ok_q       <= 1'b0;
      m_valid_q     <= 1'b0;
      req_q         <= REQ_PUT;
    end else begin
      state_q       <= state_d;
      col_q         <= col_d;
      row_q         <= row_d;
      row_base_q    <= row_base_d;
      top_base_q    <= top_base_d;
      sweep_addr_q  <= sweep_addr_d;
      sweep_end_q   <= sweep_end_d;
      sweep_color_q <= sweep_color_d;
      scrolled_q    <= scrolled_d;
      rd_ok_q       <= rd_ok_d;
      m_valid_q     <= m_valid_d;
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      if (s_accept) begin
        req_q <= req_e'(s_axis_tuser);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      ch_q  <= s_axis_tdata[7:0];
      idx_q <= s_axis_tdata[18:8];
    end
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

endmodule

// File: design/txcon_checker.sv
// -----------------------------------------------------------------------------
// Text console port checker
// Watches the stream ports of the console core over time.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module txcon_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  localparam int CellCount = ROWS * COLUMNS;
  localparam logic [10:0] LastRowPos = 11'((ROWS - 1) * COLUMNS);

  logic        in_accept;
  logic        out_wait;
  logic        out_scroll;
  logic        cursor_ok;
  logic [32:0] out_word;
  logic [10:0] cursor_pos;

  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign out_wait   = m_axis_tvalid && !m_axis_tready;
  assign out_scroll = m_axis_tvalid && m_axis_tuser[0];
  assign out_word   = {m_axis_tuser, m_axis_tdata};
  assign cursor_pos = m_axis_tdata[10:0];
  assign cursor_ok  = (CellCount > 2048) || (32'(cursor_pos) < CellCount);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, m_axis_tvalid && $stable(out_word))
  `ASSERT_NEXT(a_one_in_work, clk_i, rst_ni, in_accept, !s_axis_tready)
  `ASSERT_IMPLIES(a_cursor_on_screen, clk_i, rst_ni, m_axis_tvalid, cursor_ok)
  `ASSERT_IMPLIES(a_scroll_home, clk_i, rst_ni, out_scroll, cursor_pos == LastRowPos)

endmodule

bind text_console_writer_core txcon_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_txcon_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// File: tb/text_console_writer_core_tb.sv
// -----------------------------------------------------------------------------
// Text console writer core testbench
// Drives put, newline, clear, read and unused requests through the input
// stream and follows each accepted transaction with a shadow copy of the
// screen, cursor and text colour. Every output transaction is checked field
// by field against the oldest predicted reply. Directed tests cover reset
// contents, field extremes, clearing, colour settings and wrapping on the
// last row. Random traffic follows, with idle and stall phases on both sides.
// -----------------------------------------------------------------------------
module text_console_writer_core_tb;
  import txcon_pkg::*;

  localparam int Columns = 80;
  localparam int Rows = 24;
  localparam int CellCount = Columns * Rows;
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int DrainCycles = 8;
  localparam int MaxReports = 100;
  localparam int PhaseItems = 375;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
    logic        scrolled;
  } console_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;

  logic [15:0]    screen_cells [CellCount];
  int unsigned    cur_col;
  int unsigned    cur_row;
  logic [7:0]     shadow_color;
  console_reply_t expected_replies [$];
  int unsigned    error_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;

  text_console_writer_core #(
    .COLUMNS(Columns),
    .ROWS   (Rows)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic void reset_console();
    for (int k = 0; k < CellCount; k++) begin
      screen_cells[k] = {ColorReset, BlankChar};
    end
    cur_col = 0;
    cur_row = 0;
    shadow_color = ColorReset;
  endfunction

  function automatic void blank_cells(int unsigned first, int unsigned count);
    for (int unsigned k = 0; k < count && first + k < CellCount; k++) begin
      screen_cells[first + k] = {shadow_color, BlankChar};
    end
  endfunction

  function automatic logic next_row();
    cur_col = 0;
    cur_row++;
    if (cur_row < Rows) begin
      return 1'b0;
    end
    for (int k = 0; k < (Rows - 1) * Columns; k++) begin
      screen_cells[k] = screen_cells[k + Columns];
    end
    blank_cells((Rows - 1) * Columns, Columns);
    cur_row = Rows - 1;
    return 1'b1;
  endfunction

  function automatic console_reply_t advance_console(logic [1:0] req, logic [7:0] ch,
                                                    logic [10:0] idx);
    console_reply_t reply;
    int unsigned pos;
    reply = '0;
    case (req)
      REQ_PUT: begin
        if (ch == NewlineChar) begin
          reply.scrolled = next_row();
        end else begin
          pos = cur_row * Columns + cur_col;
          if (pos < CellCount) begin
            screen_cells[pos] = {shadow_color, ch};
          end
          cur_col++;
          if (cur_col >= Columns) begin
            reply.scrolled = next_row();
          end
        end
      end
      REQ_CLEAR: begin
        blank_cells(0, CellCount);
        cur_col = 0;
        cur_row = 0;
      end
      REQ_READ: begin
        if (idx < CellCount) begin
          reply.cell_char  = screen_cells[idx][7:0];
          reply.cell_color = screen_cells[idx][15:8];
        end
      end
      default: begin
      end
    endcase
    reply.cursor_pos = 11'(cur_row * Columns + cur_col);
    return reply;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    error_count++;
    if (error_count <= MaxReports) begin
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    console_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("output transaction with no request waiting", m_axis_tdata, 0);
      end else begin
        want = expected_replies.pop_front();
        if (m_axis_tdata[10:0] !== want.cursor_pos) begin
          report_mismatch("cursor_pos", m_axis_tdata[10:0], want.cursor_pos);
        end
        if (m_axis_tdata[18:11] !== want.cell_char) begin
          report_mismatch("cell_char", m_axis_tdata[18:11], want.cell_char);
        end
        if (m_axis_tdata[26:19] !== want.cell_color) begin
          report_mismatch("cell_color", m_axis_tdata[26:19], want.cell_color);
        end
        if (m_axis_tuser[0] !== want.scrolled) begin
          report_mismatch("scrolled", m_axis_tuser[0], want.scrolled);
        end
      end
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [7:0] ch,
                              input logic [10:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {5'b0, idx, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_replies.push_back(advance_console(req, ch, idx));
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_request(REQ_PUT, ch, 11'($urandom_range(2047)));
  endtask

  task automatic read_cell(input int unsigned idx);
    send_request(REQ_READ, 8'($urandom_range(255)), 11'(idx));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_text_color(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_color = value;
  endtask

  task automatic send_random_request();
    int unsigned pick;
    int unsigned here;
    logic [10:0] idx;
    pick = $urandom_range(999);
    idx  = 11'($urandom_range(2047));
    here = cur_row * Columns + cur_col;
    if (pick < 6) begin
      send_request(REQ_CLEAR, 8'($urandom_range(255)), idx);
    end else if (pick < 25) begin
      send_request(ReqUnused, 8'($urandom_range(255)), idx);
    end else if (pick < 190) begin
      if (pick < 110 && here > 0) begin
        idx = 11'(here - $urandom_range(1, (here < 4) ? here : 4));
      end else if (pick < 170) begin
        idx = 11'($urandom_range(CellCount - 1));
      end
      read_cell(idx);
    end else if (pick < 240) begin
      put_char(NewlineChar);
    end else begin
      put_char(8'($urandom_range(255)));
    end
  endtask

  task automatic test_reset_contents();
    read_cell(0);
    read_cell(1);
    read_cell(CellCount - 1);
    read_cell(CellCount);
    read_cell(2047);
    read_cell(1000);
  endtask

  task automatic test_put_extremes();
    send_request(REQ_PUT, 8'h00, 11'h000);
    send_request(REQ_PUT, 8'hFF, 11'h7FF);
    put_char(8'h41);
    put_char(NewlineChar);
    send_request(ReqUnused, 8'hFF, 11'h7FF);
    send_request(ReqUnused, 8'h00, 11'h000);
    read_cell(0);
    read_cell(1);
    read_cell(2);
    read_cell(Columns);
  endtask

  task automatic test_clear();
    put_char(8'h5A);
    send_request(REQ_CLEAR, 8'hFF, 11'h7FF);
    read_cell(0);
    read_cell(Columns + 1);
    put_char(8'h61);
    read_cell(0);
  endtask

  task automatic test_colour_settings();
    logic [7:0] colours [3];
    colours = '{8'h00, 8'hFF, 8'($urandom_range(255))};
    foreach (colours[i]) begin
      wait_drained();
      write_text_color(colours[i]);
      put_char(8'h58);
      put_char(8'h59);
      read_cell(cur_row * Columns + cur_col - 1);
      send_request(REQ_CLEAR, 8'h00, 11'h000);
      read_cell(CellCount - 1);
      read_cell(0);
    end
  endtask

  task automatic test_last_row_wrap();
    send_request(REQ_CLEAR, 8'h00, 11'h000);
    repeat (Rows - 1) put_char(NewlineChar);
    repeat (Columns - 1) put_char(8'($urandom_range(32, 126)));
    put_char(8'h7E);
    read_cell((Rows - 1) * Columns - 1);
    read_cell((Rows - 1) * Columns);
    put_char(8'h21);
    put_char(NewlineChar);
    read_cell((Rows - 2) * Columns);
    read_cell(CellCount - 1);
  endtask

  task automatic test_random_traffic();
    int unsigned idle_modes [4][2];
    idle_modes = '{'{0, 0}, '{83, 0}, '{0, 83}, '{10, 10}};
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case ($urandom_range(3))
        0: write_text_color(8'h00);
        1: write_text_color(8'hFF);
        default: write_text_color(8'($urandom_range(255)));
      endcase
      send_idle_pct  = idle_modes[p][0];
      recv_stall_pct = idle_modes[p][1];
      repeat (PhaseItems) send_random_request();
    end
  endtask

  initial begin
    reset_console();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_contents();
    test_put_extremes();
    test_clear();
    test_colour_settings();
    test_last_row_wrap();
    test_random_traffic();
    wait_drained();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

endmodule
